// ===== rtl/debounced_pulse_gate_counter_core_assert.svh =====
// assertion macros for the rtl of the debounced pulse gate counter
// depends on nothing; included inside module bodies
`ifndef DEBOUNCED_PULSE_GATE_COUNTER_CORE_ASSERT_SVH
`define DEBOUNCED_PULSE_GATE_COUNTER_CORE_ASSERT_SVH

// condition holds on every clock outside reset
`define DPGC_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed: invariant");

// same-cycle implication
`define DPGC_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

// next-cycle implication
`define DPGC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/dpgc_pkg.sv =====
// types and constants of the debounced pulse gate counter
// depends on nothing
`default_nettype none

package dpgc_pkg;

   localparam int PULSE_W  = 16;
   localparam int GATE_W   = 16;
   localparam int SETTLE_W = 8;
   localparam int CSR_W    = 16;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] REG_GATE_LIMIT     = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_DEBOUNCE_TICKS = 1'b1;

   localparam logic [GATE_W-1:0]   GATE_LIMIT_RST     = 16'd999;
   localparam logic [SETTLE_W-1:0] DEBOUNCE_TICKS_RST = 8'd2;

   localparam logic [GATE_W-1:0]   GATE_MAX   = '1;
   localparam logic [SETTLE_W-1:0] SETTLE_MAX = '1;

   typedef enum logic [5:0] {
      PH_IDLE = 6'b000001,
      PH_INIT = 6'b000010,
      PH_FALL = 6'b000100,
      PH_DEB1 = 6'b001000,
      PH_RISE = 6'b010000,
      PH_DEB2 = 6'b100000
   } phase_type;

   typedef struct packed {
      phase_type           phase;
      logic [PULSE_W-1:0]  pulses;
      logic [GATE_W-1:0]   gate_ticks;
      logic [SETTLE_W-1:0] settle_ticks;
      logic                window_done;
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/dpgc_if.sv =====
// request and response channel interfaces of the debounced pulse gate counter
// depends on dpgc_pkg
`default_nettype none

interface dpgc_req_if;
   logic valid;
   logic ready;
   logic cmd;
   logic pin_level;

   modport source (output valid, output cmd, output pin_level, input ready);
   modport sink   (input valid, input cmd, input pin_level, output ready);
endinterface

interface dpgc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [dpgc_pkg::PULSE_W-1:0] pulse_total;
   logic                        sample_done;

   modport source (output valid, output pulse_total, output sample_done, input ready);
   modport sink   (input valid, input pulse_total, input sample_done, output ready);
endinterface

`default_nettype wire

// ===== rtl/dpgc_tick.sv =====
// next-state logic for one request: start command or timer tick
// depends on dpgc_pkg
`default_nettype none

module dpgc_tick (
   input  dpgc_pkg::state_type                  state_cur,
   input  logic                                 cmd,
   input  logic                                 pin_level,
   input  logic [dpgc_pkg::GATE_W-1:0]          gate_limit,
   input  logic [dpgc_pkg::SETTLE_W-1:0]        debounce_ticks,
   output dpgc_pkg::state_type                  state_nxt
);
   import dpgc_pkg::*;

   state_type st;
   logic      settle_hit;

   always_comb begin
      st = state_cur;
      settle_hit = 1'b0;
      if (cmd) begin
         st.phase       = PH_INIT;
         st.window_done = 1'b0;
      end else begin
         if (st.settle_ticks != SETTLE_MAX) begin
            st.settle_ticks = st.settle_ticks + SETTLE_W'(1);
         end
         if ((st.phase != PH_IDLE) && (st.gate_ticks != GATE_MAX)) begin
            st.gate_ticks = st.gate_ticks + GATE_W'(1);
         end
         // gate window closes
         if (st.gate_ticks > gate_limit) begin
            st.gate_ticks  = '0;
            st.phase       = PH_IDLE;
            st.window_done = 1'b1;
         end
         settle_hit = (st.settle_ticks == debounce_ticks);
         unique case (st.phase)
            PH_INIT: begin
               st.pulses     = '0;
               st.gate_ticks = '0;
               st.phase      = PH_FALL;
            end
            PH_FALL: begin
               if (!pin_level) begin
                  st.settle_ticks = '0;
                  st.phase        = PH_DEB1;
               end
            end
            PH_DEB1: begin
               if (settle_hit) begin
                  if (pin_level) begin
                     st.phase = PH_FALL;
                  end else begin
                     st.pulses = st.pulses + PULSE_W'(1);
                     st.phase  = PH_RISE;
                  end
               end
            end
            PH_RISE: begin
               if (pin_level) begin
                  st.settle_ticks = '0;
                  st.phase        = PH_DEB2;
               end
            end
            PH_DEB2: begin
               if (settle_hit) begin
                  st.phase = pin_level ? PH_FALL : PH_RISE;
               end
            end
            default: begin
               // idle: the phase machine does nothing
            end
         endcase
      end
      state_nxt = st;
   end

endmodule

`default_nettype wire

// ===== rtl/debounced_pulse_gate_counter_core.sv =====
// top level of the debounced pulse gate counter: handshake, state, registers
// depends on dpgc_pkg, dpgc_if, dpgc_tick and the assertion macro header
`default_nettype none

//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+-------------------------------------
//  req_ch   | in  | valid / ready | cmd, pin_level
//  rsp_ch   | out | valid / ready | pulse_total[15:0], sample_done
//  csr_*    | in  | csr_we        | csr_index[0:0], csr_wdata[15:0]
//
//  each request passes through the input register and then the response
//  register; one request per cycle sustained unless the response stalls
//  the state update sits between the two registers, so back-to-back requests
//  see each other's state with no bubble
//  reset is synchronous and clears all control state and the window state
//  a stalled response holds; the input register still fills behind it

module debounced_pulse_gate_counter_core (
   input  logic                               clock,
   input  logic                               reset,
   dpgc_req_if.sink                           req_ch,
   dpgc_rsp_if.source                         rsp_ch,
   input  logic                               csr_we,
   input  logic [dpgc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [dpgc_pkg::CSR_W-1:0]         csr_wdata
);
   import dpgc_pkg::*;

   `include "debounced_pulse_gate_counter_core_assert.svh"

   // configuration registers
   logic [GATE_W-1:0]   gate_limit_ff;
   logic [SETTLE_W-1:0] debounce_ticks_ff;

   // input register
   logic s1_valid_ff, s1_valid_in;
   logic s1_cmd_ff;
   logic s1_pin_ff;

   // window state and response register
   state_type           state_ff, state_nxt;
   logic                out_valid_ff, out_valid_in;
   logic [PULSE_W-1:0]  out_pulses_ff;
   logic                out_done_ff;

   logic advance;   // input register moves into the response register
   logic take;      // request accepted this cycle

   assign advance = !out_valid_ff || rsp_ch.ready;
   assign req_ch.ready = !s1_valid_ff || advance;
   assign take = req_ch.valid && req_ch.ready;

   assign s1_valid_in  = take ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign out_valid_in = advance ? s1_valid_ff : out_valid_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         gate_limit_ff     <= GATE_LIMIT_RST;
         debounce_ticks_ff <= DEBOUNCE_TICKS_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_GATE_LIMIT:     gate_limit_ff     <= csr_wdata[GATE_W-1:0];
            REG_DEBOUNCE_TICKS: debounce_ticks_ff <= csr_wdata[SETTLE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (take) begin
         s1_cmd_ff <= req_ch.cmd;
         s1_pin_ff <= req_ch.pin_level;
      end
   end

   // one request worth of state update
   dpgc_tick u_tick (
      .state_cur      (state_ff),
      .cmd            (s1_cmd_ff),
      .pin_level      (s1_pin_ff),
      .gate_limit     (gate_limit_ff),
      .debounce_ticks (debounce_ticks_ff),
      .state_nxt      (state_nxt)
   );

   // state and response register; state only moves when a request completes
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase        <= PH_INIT;
         state_ff.pulses       <= '0;
         state_ff.gate_ticks   <= '0;
         state_ff.settle_ticks <= '0;
         state_ff.window_done  <= 1'b0;
         out_valid_ff          <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (advance && s1_valid_ff) begin
            state_ff <= state_nxt;
         end
      end
      if (advance && s1_valid_ff) begin
         out_pulses_ff <= state_nxt.pulses;
         out_done_ff   <= state_nxt.window_done;
      end
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.pulse_total = out_pulses_ff;
   assign rsp_ch.sample_done = out_done_ff;

   // a waiting request is never dropped while the response stalls
   `DPGC_ASSERT_NEXT(a_hold_s1, clock, reset,
      s1_valid_ff && out_valid_ff && !rsp_ch.ready, s1_valid_ff)
   // an empty input register always takes a request
   `DPGC_ASSERT_IMPL(a_ready_empty, clock, reset, !s1_valid_ff, req_ch.ready)
   // a closed window stays idle until a start command
   `DPGC_ASSERT_IMPL(a_done_idle, clock, reset,
      state_ff.window_done, state_ff.phase == PH_IDLE)
   // a start command opens the init phase with done cleared
   `DPGC_ASSERT_NEXT(a_start, clock, reset,
      s1_valid_ff && s1_cmd_ff && advance,
      state_ff.phase == PH_INIT && !state_ff.window_done)

endmodule

`default_nettype wire

// ===== tb/debounced_pulse_gate_counter_core_tb.sv =====
`timescale 1ns / 1ps
// self-checking bench for debounced_pulse_gate_counter_core: predicts every response
// depends on dpgc_pkg and the dpgc_req_if / dpgc_rsp_if channel interfaces

module debounced_pulse_gate_counter_core_tb;
   import dpgc_pkg::*;

   // request command codes
   localparam logic CMD_TICK  = 1'b0;
   localparam logic CMD_START = 1'b1;

   // two register stages between request and response
   localparam int LATENCY = 2;
   // cycles with no handshake on either side before giving up
   localparam int STALL_LIMIT = 4000;
   // random requests per configuration phase, six phases
   localparam int PHASE_ITEMS = 170;

   typedef struct packed {
      logic [PULSE_W-1:0] total;
      logic               done;
   } count_result_type;

   logic clock;
   logic reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   dpgc_req_if req_ch();
   dpgc_rsp_if rsp_ch();

   debounced_pulse_gate_counter_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor copy of the window state and the two registers
   phase_type           stage;
   logic [PULSE_W-1:0]  pulse_cnt;
   logic [GATE_W-1:0]   gate_cnt;
   logic [SETTLE_W-1:0] settle_cnt;
   logic                window_closed;
   logic [GATE_W-1:0]   gate_lim;
   logic [SETTLE_W-1:0] deb_len;

   // responses still owed by the block, oldest first
   count_result_type pending_counts[$];

   // idling switches for the two sides
   bit idle_on;
   bit stall_on;

   int errors;
   int reqs_sent;
   int rsps_checked;
   int settings_used;
   int windows_closed;
   int quiet_cycles;

   // clock, 10 ns period
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 10);
      end
      return $urandom_range(20, 60);
   endfunction

   // apply one accepted request to the predicted state and queue the response
   function automatic void advance_counter(input logic cmd, input logic pin_hi);
      count_result_type r;
      if (cmd == CMD_START) begin
         // restart: init phase clears the pulse and gate counters on the next tick, unless the gate window closes first
         stage         = PH_INIT;
         window_closed = 1'b0;
      end else begin
         if (settle_cnt != SETTLE_MAX) settle_cnt++;
         if (stage != PH_IDLE && gate_cnt != GATE_MAX) gate_cnt++;
         // gate window over: close before the phase machine runs
         if (gate_cnt > gate_lim) begin
            gate_cnt      = '0;
            stage         = PH_IDLE;
            window_closed = 1'b1;
            windows_closed++;
         end
         case (stage)
            PH_INIT: begin
               pulse_cnt = '0;
               gate_cnt  = '0;
               stage     = PH_FALL;
            end
            PH_FALL: begin
               if (!pin_hi) begin
                  settle_cnt = '0;
                  stage      = PH_DEB1;
               end
            end
            PH_DEB1: begin
               // recheck the level once the settle time is reached
               if (settle_cnt == deb_len) begin
                  if (pin_hi) begin
                     stage = PH_FALL;
                  end else begin
                     pulse_cnt++;
                     stage = PH_RISE;
                  end
               end
            end
            PH_RISE: begin
               if (pin_hi) begin
                  settle_cnt = '0;
                  stage      = PH_DEB2;
               end
            end
            PH_DEB2: begin
               if (settle_cnt == deb_len) stage = pin_hi ? PH_FALL : PH_RISE;
            end
            default: ;
         endcase
      end
      r.total = pulse_cnt;
      r.done  = window_closed;
      pending_counts.push_back(r);
   endfunction

   // drive one request at the falling edge, hold until the block takes it
   task automatic send_req(input logic cmd, input logic lvl);
      int gap;
      gap = idle_on ? pick_gap() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.cmd       <= cmd;
      req_ch.pin_level <= lvl;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      reqs_sent++;
      advance_counter(cmd, lvl);
   endtask

   // stop sending and let every owed response come back
   task automatic wait_results();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_counts.size() != 0) @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // registers only change with the block drained
   task automatic set_config(input logic [GATE_W-1:0] lim, input logic [SETTLE_W-1:0] deb);
      wait_results();
      write_csr(REG_GATE_LIMIT, lim);
      write_csr(REG_DEBOUNCE_TICKS, CSR_W'(deb));
      gate_lim = lim;
      deb_len  = deb;
      settings_used++;
   endtask

   // reset values, one full pulse with the default debounce, restart mid-window
   task automatic test_default_pulse();
      send_req(CMD_TICK, 1'b1);
      send_req(CMD_TICK, 1'b0);
      send_req(CMD_TICK, 1'b0);
      send_req(CMD_TICK, 1'b0);
      send_req(CMD_TICK, 1'b1);
      send_req(CMD_TICK, 1'b1);
      send_req(CMD_TICK, 1'b1);
      send_req(CMD_START, 1'b1);
      send_req(CMD_TICK, 1'b0);
   endtask

   // window closes on the first counted tick, then restart from idle
   task automatic test_zero_gate_limit();
      set_config('0, 8'd1);
      send_req(CMD_START, 1'b0);
      send_req(CMD_TICK, 1'b1);
      send_req(CMD_TICK, 1'b0);
      send_req(CMD_TICK, 1'b0);
      send_req(CMD_START, 1'b1);
      send_req(CMD_TICK, 1'b1);
   endtask

   // zero settle time: the debounce phase never matches and waits for the gate
   task automatic test_zero_debounce();
      set_config(16'd6, '0);
      send_req(CMD_START, 1'b1);
      send_req(CMD_TICK, 1'b1);
      send_req(CMD_TICK, 1'b0);
      send_req(CMD_TICK, 1'b0);
      send_req(CMD_TICK, 1'b1);
      send_req(CMD_TICK, 1'b0);
      send_req(CMD_TICK, 1'b0);
      send_req(CMD_TICK, 1'b0);
      send_req(CMD_TICK, 1'b1);
   endtask

   // widest gate and settle values
   task automatic test_max_limits();
      set_config(GATE_MAX, SETTLE_MAX);
      send_req(CMD_START, 1'b0);
      send_req(CMD_TICK, 1'b1);
      send_req(CMD_TICK, 1'b0);
      send_req(CMD_TICK, 1'b1);
   endtask

   // pin waveforms held around the settle time, glitches, stray ticks and restarts
   task automatic test_random_windows();
      logic [GATE_W-1:0]   lim;
      logic [SETTLE_W-1:0] deb;
      logic                lvl;
      int                  target;
      int                  hold;
      int                  r;
      for (int k = 0; k < 6; k++) begin
         case (k)
            0: begin
               lim = 16'd1;
               deb = 8'd1;
            end
            1: begin
               lim = GATE_MAX - GATE_W'(1);
               deb = SETTLE_MAX;
            end
            2: begin
               lim = GATE_W'($urandom_range(20, 150));
               deb = SETTLE_W'($urandom_range(1, 6));
            end
            default: begin
               lim = GATE_W'($urandom_range(8, 200));
               deb = SETTLE_W'($urandom_range(1, 8));
            end
         endcase
         set_config(lim, deb);
         // one phase runs flat out on both sides
         idle_on  = (k != 2);
         stall_on = (k != 2);
         send_req(CMD_START, 1'($urandom_range(0, 1)));
         lvl    = 1'b1;
         target = reqs_sent + PHASE_ITEMS;
         while (reqs_sent < target) begin
            r = $urandom_range(0, 99);
            if (r < 3 || (window_closed && r < 30)) begin
               send_req(CMD_START, 1'($urandom_range(0, 1)));
            end else if (r < 5) begin
               // hold off until the block has answered everything
               wait_results();
            end else if (r < 15) begin
               send_req(CMD_TICK, 1'($urandom_range(0, 1)));
            end else begin
               lvl = ~lvl;
               case ($urandom_range(0, 3))
                  0:       hold = $urandom_range(1, (deb > 1) ? deb - 1 : 1);
                  1, 2:    hold = $urandom_range(deb, deb + 2);
                  default: hold = $urandom_range(1, 2 * deb + 4);
               endcase
               repeat (hold) begin
                  if (reqs_sent < target) send_req(CMD_TICK, lvl);
               end
            end
         end
      end
      idle_on  = 1'b1;
      stall_on = 1'b1;
   endtask

   // response side: random back-pressure driven at the falling edge
   initial begin
      int stall;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         stall = stall_on ? pick_gap() : 0;
         if (stall == 0) begin
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
      end
   end

   // every accepted response against the oldest prediction
   always @(posedge clock) begin
      count_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_counts.size() == 0) begin
            $display("%0t: unexpected response: pulse_total %0d sample_done %0b",
                     $time, rsp_ch.pulse_total, rsp_ch.sample_done);
            errors++;
         end else begin
            want = pending_counts.pop_front();
            rsps_checked++;
            if (rsp_ch.pulse_total !== want.total) begin
               $display("%0t: pulse_total mismatch: expected %0d actual %0d",
                        $time, want.total, rsp_ch.pulse_total);
               errors++;
            end
            if (rsp_ch.sample_done !== want.done) begin
               $display("%0t: sample_done mismatch: expected %0b actual %0b",
                        $time, want.done, rsp_ch.sample_done);
               errors++;
            end
         end
      end
   end

   // watchdog: too long with no handshake on either channel ends the run
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("%0t: timeout, %0d responses outstanding", $time, pending_counts.size());
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   initial begin
      // every input known from time zero
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.cmd       = CMD_TICK;
      req_ch.pin_level = 1'b0;
      csr_we           = 1'b0;
      csr_index        = REG_GATE_LIMIT;
      csr_wdata        = '0;
      quiet_cycles     = 0;
      idle_on          = 1'b1;
      stall_on         = 1'b1;

      // predictor at its reset values
      stage         = PH_INIT;
      pulse_cnt     = '0;
      gate_cnt      = '0;
      settle_cnt    = '0;
      window_closed = 1'b0;
      gate_lim      = GATE_LIMIT_RST;
      deb_len       = DEBOUNCE_TICKS_RST;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_default_pulse();
      test_zero_gate_limit();
      test_zero_debounce();
      test_max_limits();
      test_random_windows();

      wait_results();
      $display("run covered %0d requests and %0d checked responses over %0d settings,",
               reqs_sent, rsps_checked, settings_used);
      $display("with %0d gate windows closed, zero and widest limits included",
               windows_closed);
      if (errors == 0 && pending_counts.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== debounced_pulse_gate_counter_core.f =====
+incdir+rtl
rtl/dpgc_pkg.sv
rtl/dpgc_if.sv
rtl/dpgc_tick.sv
rtl/debounced_pulse_gate_counter_core.sv
tb/debounced_pulse_gate_counter_core_tb.sv
